FILE: rtl/core/dpalu_pkg.sv
package dpalu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OPCODE_W   = 4;
    localparam int ROTATE_W   = 5;
    localparam int SHAMT_W    = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_type;

    typedef struct packed {
        logic                 en;
        t_shift_type          kind;
        logic [SHAMT_W-1:0]   amount;
        logic                 from_reg;
    } t_shift_ctrl;

    typedef struct packed {
        logic v;
        logic c;
        logic z;
        logic n;
    } t_flags;

endpackage

FILE: rtl/core/dpalu_shifter.sv
module dpalu_shifter #(
    parameter int DW = dpalu_pkg::DATA_WIDTH
) (
    input  logic [DW-1:0]                    i_value,
    input  logic [dpalu_pkg::ROTATE_W-1:0]   i_rotate,
    input  dpalu_pkg::t_shift_ctrl           i_ctrl,
    input  logic                             i_carry_in,
    output logic [DW-1:0]                    o_value,
    output logic                             o_carry
);

    localparam int AW = $clog2(DW);
    localparam logic [dpalu_pkg::SHAMT_W-1:0] AMT_FULL = dpalu_pkg::SHAMT_W'(DW);
    localparam logic [AW:0] AMT_CLAMP = (AW+1)'(DW);

    logic [2*DW-1:0]   rot_wide;
    logic [DW-1:0]     rotated;
    logic              rot_carry;
    logic              amt_zero;
    logic              amt_big;
    logic [AW:0]       amt_lim;
    logic [DW:0]       lsl_wide;
    logic [DW:0]       lsr_wide;
    logic signed [DW:0] asr_src;
    logic signed [DW:0] asr_wide;
    logic [2*DW-1:0]   ror_wide;
    logic [DW-1:0]     ror_val;

    // Immediate rotate comes first; a nonzero rotate sets the carry from the top bit
    assign rot_wide  = {i_value, i_value} >> i_rotate;
    assign rotated   = rot_wide[DW-1:0];
    assign rot_carry = (i_rotate != '0) ? rotated[DW-1] : i_carry_in;

    assign amt_zero = (i_ctrl.amount == '0);
    assign amt_big  = (i_ctrl.amount > AMT_FULL);
    // Zero maps to a full-width shift (immediate LSR/ASR #0); large amounts clamp
    assign amt_lim  = (amt_zero || amt_big || (i_ctrl.amount == AMT_FULL)) ? AMT_CLAMP
                                                                          : i_ctrl.amount[AW:0];

    assign lsl_wide = {1'b0, rotated} << amt_lim;
    assign lsr_wide = {rotated, 1'b0} >> amt_lim;
    assign asr_src  = {rotated, 1'b0};
    assign asr_wide = asr_src >>> amt_lim;
    assign ror_wide = {rotated, rotated} >> i_ctrl.amount[AW-1:0];
    assign ror_val  = ror_wide[DW-1:0];

    always_comb begin
        o_value = rotated;
        o_carry = rot_carry;
        if (i_ctrl.en) begin
            case (i_ctrl.kind)
                dpalu_pkg::SH_LSL: begin
                    if (amt_big) begin
                        o_value = '0;
                        o_carry = 1'b0;
                    end else if (!amt_zero) begin
                        o_value = lsl_wide[DW-1:0];
                        o_carry = lsl_wide[DW];
                    end
                end
                dpalu_pkg::SH_LSR: begin
                    if (amt_big) begin
                        o_value = '0;
                        o_carry = 1'b0;
                    end else if (!(amt_zero && i_ctrl.from_reg)) begin
                        o_value = lsr_wide[DW:1];
                        o_carry = lsr_wide[0];
                    end
                end
                dpalu_pkg::SH_ASR: begin
                    if (!(amt_zero && i_ctrl.from_reg)) begin
                        o_value = asr_wide[DW:1];
                        o_carry = asr_wide[0];
                    end
                end
                dpalu_pkg::SH_ROR: begin
                    if (amt_zero) begin
                        // RRX: carry flag enters the top, bit 0 leaves as carry
                        if (!i_ctrl.from_reg) begin
                            o_value = {i_carry_in, rotated[DW-1:1]};
                            o_carry = rotated[0];
                        end
                    end else begin
                        o_value = ror_val;
                        o_carry = ror_val[DW-1];
                    end
                end
                default: begin
                    o_value = rotated;
                    o_carry = rot_carry;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/data_processing_alu_with_shifter.sv
// Data-processing ALU with barrel shifter. Each transfer on the s_axis side carries one
// operation: operand B is rotated by imm_rotate, optionally shifted (LSL, LSR, ASR, ROR,
// RRX), then combined with operand A by one of the 16 data-processing opcodes. The block
// takes one operation per cycle unless m_axis stalls; a result goes from its input transfer
// through the input register, the single combinational pass through rotator, shifter and
// 33-bit adder, and the result register. Back-pressure on m_axis stalls the result register
// and a full input register; flags are all zero when set_flags is clear.
module data_processing_alu_with_shifter #(
    parameter int DATA_WIDTH = dpalu_pkg::DATA_WIDTH,
    localparam int IN_BITS  = dpalu_pkg::OPCODE_W + 2*DATA_WIDTH + dpalu_pkg::ROTATE_W
                              + 3 + dpalu_pkg::SHAMT_W + 3,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = DATA_WIDTH + 6,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode, operand_a, operand_b, imm_rotate, shift_enable, shift_type, shift_amount,
    // amount_from_register, carry_in, set_flags, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // result, write_result, flags_update, flag_negative, flag_zero, flag_carry,
    // flag_overflow, zero pad
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int DW      = DATA_WIDTH;
    localparam int OFS_A   = dpalu_pkg::OPCODE_W;
    localparam int OFS_B   = OFS_A + DW;
    localparam int OFS_ROT = OFS_B + DW;
    localparam int OFS_SEN = OFS_ROT + dpalu_pkg::ROTATE_W;
    localparam int OFS_STY = OFS_SEN + 1;
    localparam int OFS_SAM = OFS_STY + 2;
    localparam int OFS_REG = OFS_SAM + dpalu_pkg::SHAMT_W;
    localparam int OFS_CIN = OFS_REG + 1;
    localparam int OFS_SF  = OFS_CIN + 1;

    logic                                r_in_vld;
    dpalu_pkg::t_opcode                  r_opcode;
    logic [DW-1:0]                       r_a;
    logic [DW-1:0]                       r_b;
    logic [dpalu_pkg::ROTATE_W-1:0]      r_rot;
    dpalu_pkg::t_shift_ctrl              r_shift;
    logic                                r_cin;
    logic                                r_sf;

    logic                                r_out_vld;
    logic [DW-1:0]                       r_out_result;
    logic                                r_out_wr;
    logic                                r_out_fu;
    dpalu_pkg::t_flags                   r_out_flags;

    logic [DW-1:0]                       n_result;
    logic                                n_wr;
    dpalu_pkg::t_flags                   n_flags;

    logic                                advance;
    logic                                in_take;
    logic [DW-1:0]                       sh_val;
    logic                                sh_carry;
    logic                                is_arith;
    logic [DW-1:0]                       add_x;
    logic [DW-1:0]                       add_y;
    logic                                add_ci;
    logic [DW:0]                         sum;
    logic [DW-1:0]                       logic_res;
    logic                                add_v;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode        <= dpalu_pkg::t_opcode'(s_axis_tdata[dpalu_pkg::OPCODE_W-1:0]);
            r_a             <= s_axis_tdata[OFS_A +: DW];
            r_b             <= s_axis_tdata[OFS_B +: DW];
            r_rot           <= s_axis_tdata[OFS_ROT +: dpalu_pkg::ROTATE_W];
            r_shift.en      <= s_axis_tdata[OFS_SEN];
            r_shift.kind    <= dpalu_pkg::t_shift_type'(s_axis_tdata[OFS_STY +: 2]);
            r_shift.amount  <= s_axis_tdata[OFS_SAM +: dpalu_pkg::SHAMT_W];
            r_shift.from_reg <= s_axis_tdata[OFS_REG];
            r_cin           <= s_axis_tdata[OFS_CIN];
            r_sf            <= s_axis_tdata[OFS_SF];
        end
    end

    dpalu_shifter #(
        .DW (DW)
    ) u_shifter (
        .i_value    (r_b),
        .i_rotate   (r_rot),
        .i_ctrl     (r_shift),
        .i_carry_in (r_cin),
        .o_value    (sh_val),
        .o_carry    (sh_carry)
    );

    // Operand routing for the shared adder
    always_comb begin
        is_arith = 1'b1;
        add_x    = r_a;
        add_y    = sh_val;
        add_ci   = 1'b0;
        case (r_opcode)
            dpalu_pkg::OP_SUB,
            dpalu_pkg::OP_CMP: begin
                add_y  = ~sh_val;
                add_ci = 1'b1;
            end
            dpalu_pkg::OP_RSB: begin
                add_x  = sh_val;
                add_y  = ~r_a;
                add_ci = 1'b1;
            end
            dpalu_pkg::OP_ADD,
            dpalu_pkg::OP_CMN: begin
                add_ci = 1'b0;
            end
            dpalu_pkg::OP_ADC: begin
                add_ci = r_cin;
            end
            dpalu_pkg::OP_SBC: begin
                add_y  = ~sh_val;
                add_ci = r_cin;
            end
            dpalu_pkg::OP_RSC: begin
                add_x  = sh_val;
                add_y  = ~r_a;
                add_ci = r_cin;
            end
            default: begin
                is_arith = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{DW{1'b0}}, add_ci};
    assign add_v = (add_x[DW-1] ^ sum[DW-1]) & (add_y[DW-1] ^ sum[DW-1]);

    always_comb begin
        case (r_opcode)
            dpalu_pkg::OP_AND,
            dpalu_pkg::OP_TST: logic_res = r_a & sh_val;
            dpalu_pkg::OP_EOR,
            dpalu_pkg::OP_TEQ: logic_res = r_a ^ sh_val;
            dpalu_pkg::OP_ORR: logic_res = r_a | sh_val;
            dpalu_pkg::OP_MOV: logic_res = sh_val;
            dpalu_pkg::OP_BIC: logic_res = r_a & ~sh_val;
            default:           logic_res = ~sh_val;
        endcase
    end

    always_comb begin
        n_result  = is_arith ? sum[DW-1:0] : logic_res;
        n_wr      = !(r_opcode == dpalu_pkg::OP_TST || r_opcode == dpalu_pkg::OP_TEQ ||
                      r_opcode == dpalu_pkg::OP_CMP || r_opcode == dpalu_pkg::OP_CMN);
        n_flags.n = r_sf & n_result[DW-1];
        n_flags.z = r_sf & (n_result == '0);
        n_flags.c = r_sf & (is_arith ? sum[DW] : sh_carry);
        n_flags.v = r_sf & is_arith & add_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Hold the result while the master side stalls
    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out_result <= n_result;
            r_out_wr     <= n_wr;
            r_out_fu     <= r_sf;
            r_out_flags  <= n_flags;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_flags.v, r_out_flags.c, r_out_flags.z,
                                   r_out_flags.n, r_out_fu, r_out_wr, r_out_result});

    a_take_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_vld)
        else $error("accepted transfer did not reach the input register");

    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_fu |-> r_out_flags == '0)
        else $error("flags set without flag update");

    a_nz_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_fu |->
            (r_out_flags.z == (r_out_result == '0)) && (r_out_flags.n == r_out_result[DW-1]))
        else $error("N or Z flag disagrees with result");

    a_write_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_vld |=> r_out_vld &&
            (r_out_wr == !($past(r_opcode) == dpalu_pkg::OP_TST ||
                           $past(r_opcode) == dpalu_pkg::OP_TEQ ||
                           $past(r_opcode) == dpalu_pkg::OP_CMP ||
                           $past(r_opcode) == dpalu_pkg::OP_CMN)))
        else $error("write enable wrong for opcode");

    a_logical_no_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_vld && !is_arith |=> !r_out_flags.v)
        else $error("overflow set on logical operation");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int IN_W        = 88;
    localparam int OUT_W       = 40;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 8;

    // one operation, lowest field last (matches the tdata layout)
    typedef struct packed {
        logic                   set_flags;
        logic                   carry_in;
        logic                   from_reg;
        logic [7:0]             amount;
        dpalu_pkg::t_shift_type kind;
        logic                   shift_en;
        logic [4:0]             rot;
        logic [31:0]            opb;
        logic [31:0]            opa;
        dpalu_pkg::t_opcode     op;
    } t_alu_op;

    typedef struct packed {
        logic        v;
        logic        c;
        logic        z;
        logic        n;
        logic        flags_upd;
        logic        wr;
        logic [31:0] res;
    } t_alu_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_tvalid = 1'b0;
    logic [IN_W-1:0]  in_tdata = '0;
    logic             out_tready = 1'b1;
    logic             s_axis_tready;
    logic             m_axis_tvalid;
    logic [OUT_W-1:0] m_axis_tdata;

    t_alu_res pending_results[$];
    t_alu_res got_res;
    t_alu_res want_res;
    int       errors = 0;
    int       idle_cycles = 0;
    bit       idle_on = 1'b1;

    logic [31:0] edge_vals[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

    always #5 i_clk = ~i_clk;

    data_processing_alu_with_shifter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (in_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_tdata),      // opcode, operand_a, operand_b, imm_rotate,
                                        // shift_enable, shift_type, shift_amount,
                                        // amount_from_register, carry_in, set_flags
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (out_tready),
        .m_axis_tdata  (m_axis_tdata)   // result, write_result, flags_update, flag_negative,
                                        // flag_zero, flag_carry, flag_overflow
    );

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

    // returns {shifter carry, shifted value}
    function automatic logic [32:0] barrel(input logic [31:0] x,
                                           input dpalu_pkg::t_shift_type kind,
                                           input logic [7:0] amt, input logic from_reg,
                                           input logic cin, input logic c0);
        logic [7:0]  n;
        logic [31:0] y;
        n = amt;
        case (kind)
            dpalu_pkg::SH_LSL: begin
                if (n == 0) return {c0, x};
                if (n < 32) return {x[32-n], x << n};
                return {(n == 32) ? x[0] : 1'b0, 32'd0};
            end
            dpalu_pkg::SH_LSR: begin
                if (n == 0 && from_reg) return {c0, x};
                if (n == 0) n = 8'd32;
                if (n < 32) return {x[n-1], x >> n};
                return {(n == 32) ? x[31] : 1'b0, 32'd0};
            end
            dpalu_pkg::SH_ASR: begin
                if (n == 0 && from_reg) return {c0, x};
                if (n == 0) n = 8'd32;
                if (n < 32) begin
                    y = $signed(x) >>> n;
                    return {x[n-1], y};
                end
                return {x[31], {32{x[31]}}};
            end
            default: begin
                // immediate ROR #0 is RRX
                if (n == 0) return from_reg ? {c0, x} : {x[0], cin, x[31:1]};
                if (n[4:0] == 0) return {x[31], x};
                y = ror32(x, n[4:0]);
                return {y[31], y};
            end
        endcase
    endfunction

    // returns {overflow, carry, sum}
    function automatic logic [33:0] add33(input logic [31:0] a, input logic [31:0] b,
                                          input logic cin);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        return {(a[31] ^ s[31]) & (b[31] ^ s[31]), s[32], s[31:0]};
    endfunction

    function automatic t_alu_res alu_predict(input t_alu_op t);
        logic [31:0] b;
        logic [31:0] r;
        logic        sc;
        logic        c;
        logic        v;
        logic        arith;
        logic [32:0] sh;
        logic [33:0] sum;
        t_alu_res    o;
        b = t.opb;
        sc = t.carry_in;
        if (t.rot != 0) begin
            b = ror32(b, t.rot);
            sc = b[31];
        end
        if (t.shift_en) begin
            sh = barrel(b, t.kind, t.amount, t.from_reg, t.carry_in, sc);
            b = sh[31:0];
            sc = sh[32];
        end
        arith = 1'b1;
        sum = '0;
        case (t.op)
            dpalu_pkg::OP_SUB, dpalu_pkg::OP_CMP: sum = add33(t.opa, ~b, 1'b1);
            dpalu_pkg::OP_RSB:                    sum = add33(b, ~t.opa, 1'b1);
            dpalu_pkg::OP_ADD, dpalu_pkg::OP_CMN: sum = add33(t.opa, b, 1'b0);
            dpalu_pkg::OP_ADC:                    sum = add33(t.opa, b, t.carry_in);
            dpalu_pkg::OP_SBC:                    sum = add33(t.opa, ~b, t.carry_in);
            dpalu_pkg::OP_RSC:                    sum = add33(b, ~t.opa, t.carry_in);
            default:                              arith = 1'b0;
        endcase
        if (arith) begin
            r = sum[31:0];
            c = sum[32];
            v = sum[33];
        end else begin
            case (t.op)
                dpalu_pkg::OP_AND, dpalu_pkg::OP_TST: r = t.opa & b;
                dpalu_pkg::OP_EOR, dpalu_pkg::OP_TEQ: r = t.opa ^ b;
                dpalu_pkg::OP_ORR:                    r = t.opa | b;
                dpalu_pkg::OP_MOV:                    r = b;
                dpalu_pkg::OP_BIC:                    r = t.opa & ~b;
                default:                              r = ~b;
            endcase
            c = sc;
            v = 1'b0;
        end
        o.res = r;
        o.wr = !(t.op == dpalu_pkg::OP_TST || t.op == dpalu_pkg::OP_TEQ ||
                 t.op == dpalu_pkg::OP_CMP || t.op == dpalu_pkg::OP_CMN);
        o.flags_upd = t.set_flags;
        o.n = t.set_flags & r[31];
        o.z = t.set_flags & (r == 0);
        o.c = t.set_flags & c;
        o.v = t.set_flags & v;
        return o;
    endfunction

    function automatic t_alu_op make_op(input dpalu_pkg::t_opcode op, input logic [31:0] a,
                                        input logic [31:0] b, input logic [4:0] rot,
                                        input logic en, input dpalu_pkg::t_shift_type kind,
                                        input logic [7:0] amt, input logic from_reg,
                                        input logic cin, input logic sf);
        t_alu_op t;
        t.op = op;
        t.opa = a;
        t.opb = b;
        t.rot = rot;
        t.shift_en = en;
        t.kind = kind;
        t.amount = amt;
        t.from_reg = from_reg;
        t.carry_in = cin;
        t.set_flags = sf;
        return t;
    endfunction

    function automatic logic [31:0] pick_operand();
        if ($urandom_range(0, 7) == 0) return edge_vals[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'(31 + $urandom_range(0, 2));
            2:       return 8'($urandom_range(0, 255));
            3:       return 8'(32 * $urandom_range(1, 7));
            default: return 8'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic t_alu_op random_op();
        return make_op(dpalu_pkg::t_opcode'($urandom_range(0, 15)), pick_operand(),
                       pick_operand(),
                       $urandom_range(0, 1) ? 5'($urandom_range(1, 31)) : 5'd0,
                       $urandom_range(0, 3) != 0,
                       dpalu_pkg::t_shift_type'($urandom_range(0, 3)),
                       pick_amount(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3) != 0);
    endfunction

    // entered and left at a falling edge
    task automatic send_op(input t_alu_op t);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            in_tvalid <= 1'b0;
            in_tdata <= IN_W'({$urandom, $urandom, $urandom});
            repeat (gap) @(negedge i_clk);
        end
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, t};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(alu_predict(t));
        @(negedge i_clk);
    endtask

    task automatic test_opcodes();
        for (int i = 0; i < 16; i++) begin
            send_op(make_op(dpalu_pkg::t_opcode'(i), edge_vals[i % 4],
                            edge_vals[(i + 1) % 4] ^ 32'h1, 5'd0, 1'b0, dpalu_pkg::SH_LSL,
                            8'd0, 1'b0, i[0], 1'b1));
        end
        // signed overflow on add
        send_op(make_op(dpalu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h1, 5'd0, 1'b0, dpalu_pkg::SH_LSL,
                        8'd0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_shift_rules();
        // immediate zero amounts, RRX included
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h8000_0001, 5'd0, 1'b1, dpalu_pkg::SH_LSL,
                        8'd0, 1'b0, 1'b1, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h8000_0000, 5'd0, 1'b1, dpalu_pkg::SH_LSR,
                        8'd0, 1'b0, 1'b0, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h8000_0000, 5'd0, 1'b1, dpalu_pkg::SH_ASR,
                        8'd0, 1'b0, 1'b0, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h0000_0001, 5'd0, 1'b1, dpalu_pkg::SH_ROR,
                        8'd0, 1'b0, 1'b1, 1'b1));
        // register zero amount keeps value and carry
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h1234_5678, 5'd0, 1'b1, dpalu_pkg::SH_ROR,
                        8'd0, 1'b1, 1'b0, 1'b1));
        // amounts of 32 and beyond
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h0000_0001, 5'd0, 1'b1, dpalu_pkg::SH_LSL,
                        8'd32, 1'b1, 1'b0, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h8000_0000, 5'd0, 1'b1, dpalu_pkg::SH_LSR,
                        8'd32, 1'b1, 1'b0, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'hFFFF_FFFF, 5'd0, 1'b1, dpalu_pkg::SH_LSL,
                        8'd33, 1'b0, 1'b1, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h7FFF_FFFF, 5'd0, 1'b1, dpalu_pkg::SH_ASR,
                        8'd40, 1'b1, 1'b1, 1'b1));
        send_op(make_op(dpalu_pkg::OP_MOV, 32'd0, 32'h8000_0000, 5'd0, 1'b1, dpalu_pkg::SH_ROR,
                        8'd64, 1'b1, 1'b0, 1'b1));
        // rotated operand sets carry from bit 31, then flags off
        send_op(make_op(dpalu_pkg::OP_AND, 32'hFFFF_FFFF, 32'h0000_000F, 5'd4, 1'b0,
                        dpalu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b1));
        send_op(make_op(dpalu_pkg::OP_ORR, 32'd0, 32'hFFFF_FFFF, 5'd31, 1'b1, dpalu_pkg::SH_ASR,
                        8'd255, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_random_ops(input int count);
        for (int i = 0; i < count; i++) send_op(random_op());
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && out_tready) begin
            got_res = m_axis_tdata[37:0];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: expected nothing, actual %h",
                         $time, got_res);
            end else begin
                want_res = pending_results.pop_front();
                check_field("result", want_res.res, got_res.res);
                check_field("write_result", 32'(want_res.wr), 32'(got_res.wr));
                check_field("flags_update", 32'(want_res.flags_upd), 32'(got_res.flags_upd));
                check_field("flag_negative", 32'(want_res.n), 32'(got_res.n));
                check_field("flag_zero", 32'(want_res.z), 32'(got_res.z));
                check_field("flag_carry", 32'(want_res.c), 32'(got_res.c));
                check_field("flag_overflow", 32'(want_res.v), 32'(got_res.v));
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
                out_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                out_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_tvalid && s_axis_tready) || (m_axis_tvalid && out_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("** data_processing_alu_with_shifter: FAILED **");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_opcodes();
        test_shift_rules();
        test_random_ops(700);
        idle_on = 1'b0;
        test_random_ops(150);
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("** data_processing_alu_with_shifter: PASSED **");
        else
            $display("** data_processing_alu_with_shifter: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dpalu_pkg.sv
rtl/core/dpalu_shifter.sv
rtl/core/data_processing_alu_with_shifter.sv
bench/tb_top.sv
